// ----- hw/rtl/fir37_pkg.sv -----
package fir37_pkg;

   // Coefficient format and ROM
   localparam int COEF_BITS  = 15;
   localparam int ROM_TAPS   = 37;

   // Result format
   localparam int OUT_BITS   = 31;

   // Product shift register
   localparam int SHIFT_BITS = 5;
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd10;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   // Symmetric low-pass taps, center tap at full scale
   localparam coef_type COEF_ROM [ROM_TAPS] = '{
      -15'sd38,   -15'sd137,  15'sd0,     15'sd241,   15'sd120,
      -15'sd331,  -15'sd351,  15'sd338,   15'sd690,   -15'sd178,
      -15'sd1114, -15'sd267,  15'sd1562,  15'sd1185,  -15'sd1964,
      -15'sd3176, 15'sd2241,  15'sd11639, 15'sd16383, 15'sd11639,
      15'sd2241,  -15'sd3176, -15'sd1964, 15'sd1185,  15'sd1562,
      -15'sd267,  -15'sd1114, -15'sd178,  15'sd690,   15'sd338,
      -15'sd351,  -15'sd331,  15'sd120,   15'sd241,   15'sd0,
      -15'sd137,  -15'sd38
   };

   // Controls broadcast to every cell of the chain
   typedef struct packed {
      logic                  advance;
      logic [SHIFT_BITS-1:0] shift;
   } fir37_cell_ctrl_type;

   // Coefficient of a tap; taps past the ROM weigh zero
   function automatic coef_type coef_at(input int index);
      coef_type value;
      value = '0;
      if (index < ROM_TAPS) begin
         value = COEF_ROM[index];
      end
      return value;
   endfunction

endpackage

// ----- hw/rtl/fir37_if.sv -----
// Sample channel into the filter
interface fir37_req_if #(
   parameter int SAMPLE_BITS = 15
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Result channel out of the filter
interface fir37_rsp_if import fir37_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

// ----- hw/rtl/fir37_fixed_point_filter_top.sv -----
// Direct-form FIR filter built as a chain of TAPS cells. Each cell holds one
// sample of the delay line (newest in cell 0, all zero after reset), forms
// its tap product floor-shifted right by product_shift, and adds it onto the
// partial sum handed over by its left neighbor every cycle. A sample is taken
// while the block is idle; its result is ready once the partial sum has rippled
// through the product and sum registers of every cell, and no new sample is
// taken before then. A new sample is taken in the same cycle a result moves
// into the output register, which then waits for the sink. The sum is kept at
// full precision and saturates to the 31-bit signed range of filtered.
// product_shift resets to 10 and is written through csr_write_en/csr_wdata.
module fir37_fixed_point_filter_top import fir37_pkg::*; #(
   parameter int TAPS        = 37,
   parameter int SAMPLE_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   fir37_req_if.sink             req_ch,
   fir37_rsp_if.source           rsp_ch,
   input  logic                  csr_write_en,
   input  logic [SHIFT_BITS-1:0] csr_wdata
);

   localparam int SUM_BITS  = SAMPLE_BITS + COEF_BITS + $clog2(TAPS + 1);
   localparam int EXT_BITS  = ((SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS) + 1;
   localparam int CNT_BITS  = $clog2(TAPS + 2);
   localparam logic [CNT_BITS-1:0] DONE = CNT_BITS'(TAPS + 1);
   localparam logic signed [EXT_BITS-1:0] OUT_HI =
      EXT_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
   localparam logic signed [EXT_BITS-1:0] OUT_LO =
      EXT_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));

   logic [SHIFT_BITS-1:0]         shift_ff, shift_in;
   logic                          busy_ff, busy_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]    filtered_ff, filtered_in;
   logic                          accept;
   logic                          out_free;
   logic                          load;
   logic signed [EXT_BITS-1:0]    sum_ext;
   fir37_cell_ctrl_type           cell_ctrl;

   logic signed [SAMPLE_BITS-1:0] tap_sample [TAPS];
   logic signed [SUM_BITS-1:0]    tap_psum   [TAPS];

   // Handshake and sequencing
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign load         = busy_ff && (cnt_ff == DONE) && out_free;
   assign req_ch.ready = !busy_ff || load;
   assign accept       = req_ch.valid && req_ch.ready;

   assign shift_in = csr_write_en ? csr_wdata : shift_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (load) begin
         busy_in = 1'b0;
      end else if (busy_ff && (cnt_ff != DONE)) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // Drive the cell chain
   assign cell_ctrl.advance = accept;
   assign cell_ctrl.shift   = shift_ff;

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == 0) begin : g_head
         fir37_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .SUM_BITS    (SUM_BITS),
            .INDEX       (i)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .sample_prev (req_ch.sample),
            .psum_prev   ({SUM_BITS{1'b0}}),
            .sample_out  (tap_sample[i]),
            .psum_out    (tap_psum[i])
         );
      end else begin : g_body
         fir37_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .SUM_BITS    (SUM_BITS),
            .INDEX       (i)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .sample_prev (tap_sample[i-1]),
            .psum_prev   (tap_psum[i-1]),
            .sample_out  (tap_sample[i]),
            .psum_out    (tap_psum[i])
         );
      end
   end

   // Saturate the full sum into the result format
   assign sum_ext = EXT_BITS'(tap_psum[TAPS-1]);

   always_comb begin
      if (sum_ext > OUT_HI) begin
         filtered_in = OUT_BITS'(OUT_HI);
      end else if (sum_ext < OUT_LO) begin
         filtered_in = OUT_BITS'(OUT_LO);
      end else begin
         filtered_in = OUT_BITS'(sum_ext);
      end
   end

   // Output register: hold until the sink takes the transaction
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= SHIFT_RESET;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         filtered_ff <= filtered_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.filtered = filtered_ff;

   // Checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (cnt_ff == '0)))
      else $error("accepted sample did not start the chain sequence");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff) && ($past(cnt_ff) == DONE))
      else $error("result presented before the partial sum was complete");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= DONE))
      else $error("sequence counter ran past its end");

   a_no_accept_mid_sum: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (cnt_ff != DONE)) |-> !req_ch.ready)
      else $error("sample taken while the chain was still summing");

endmodule

// ----- hw/rtl/fir37_cell.sv -----
module fir37_cell import fir37_pkg::*; #(
   parameter int SAMPLE_BITS = 15,
   parameter int SUM_BITS    = 36,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fir37_cell_ctrl_type           ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample_prev,
   input  logic signed [SUM_BITS-1:0]    psum_prev,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   output logic signed [SUM_BITS-1:0]    psum_out
);

   localparam int       PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam coef_type COEF      = coef_at(INDEX);

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [PROD_BITS-1:0]   product;
   logic signed [PROD_BITS-1:0]   product_shifted;
   logic signed [SUM_BITS-1:0]    prod_ff, prod_in;
   logic signed [SUM_BITS-1:0]    psum_ff, psum_in;

   // Take the neighbor's sample when a transaction enters the line
   assign sample_in = ctrl.advance ? sample_prev : sample_ff;

   // Weigh the held sample, floor-shift, widen to the sum format
   assign product         = PROD_BITS'(sample_ff) * PROD_BITS'(COEF);
   assign product_shifted = product >>> ctrl.shift;
   assign prod_in         = SUM_BITS'(product_shifted);

   // Add this tap onto the partial sum from the previous cell
   assign psum_in = psum_prev + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      psum_ff <= psum_in;
   end

   assign sample_out = sample_ff;
   assign psum_out   = psum_ff;

endmodule
